FILE: src/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition in this cycle implies consequence in the same cycle.
`define HPSS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hpss assertion failed");

// Condition in this cycle implies consequence in the next cycle.
`define HPSS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hpss assertion failed");

`endif

FILE: src/hpss_pkg.sv
package hpss_pkg;

    localparam int TEMP_W      = 24;
    localparam int LIMIT_W     = 23;
    localparam int POS_W       = 6;
    localparam int SUM_W       = 27;
    localparam int CNT_W       = 3;
    localparam int REM_W       = 4;
    localparam int RECIP_SHIFT = 27;
    localparam int RECIP_W     = 26;
    localparam int PROD_W      = SUM_W + RECIP_W;

    // Stencil term counts
    localparam logic [CNT_W-1:0] TERMS3 = 3'd3;
    localparam logic [CNT_W-1:0] TERMS4 = 3'd4;
    localparam logic [CNT_W-1:0] TERMS5 = 3'd5;

    // floor(2^RECIP_SHIFT / n)
    localparam logic [RECIP_W-1:0] RECIP3 = RECIP_W'((1 << RECIP_SHIFT) / 3);
    localparam logic [RECIP_W-1:0] RECIP4 = RECIP_W'((1 << RECIP_SHIFT) / 4);
    localparam logic [RECIP_W-1:0] RECIP5 = RECIP_W'((1 << RECIP_SHIFT) / 5);

    // Register indexes
    localparam logic CFG_HEATER = 1'b0;
    localparam logic CFG_LIMIT  = 1'b1;

    typedef logic signed [TEMP_W-1:0] temp_t;

    typedef struct packed {
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        logic             last;
    } hpss_meta_t;

    function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] n);
        logic [RECIP_W-1:0] m;
        case (n)
            TERMS3:  m = RECIP3;
            TERMS4:  m = RECIP4;
            default: m = RECIP5;
        endcase
        return m;
    endfunction

    // Offset a signed value by 2^23 so that sums stay non-negative.
    function automatic logic [SUM_W-1:0] biased(input temp_t v);
        return SUM_W'({~v[TEMP_W-1], v[TEMP_W-2:0]});
    endfunction

endpackage

FILE: src/heat_plate_stencil_sweep_core.sv
// Channel  Signals                                              Direction
// in       in_valid, in_ready, old_temp                         into block
// out      out_valid, out_ready, new_temp, cell_row, cell_col,  out of block
//          sweep_last, settled, largest_change
// cfg      cfg_valid, cfg_ready, cfg_index, cfg_data            into block
//
// One cell per cycle is taken while a sweep runs and out is not stalled; the result
// of a transfer passes the sum, divider estimate, quotient, change and output
// registers. After the last cell of a sweep, in_ready stays low while the final
// row drains out of the tap chain of 2*COLS cells.
// Reset clears the position counters, pipeline valids, running maximum and
// both registers. A stall on out holds the whole pipeline and the tap chain.
module heat_plate_stencil_sweep_core #(
    parameter int ROWS = 8,
    parameter int COLS = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  hpss_pkg::temp_t               old_temp,
    output logic                          out_valid,
    input  logic                          out_ready,
    output hpss_pkg::temp_t               new_temp,
    output logic [hpss_pkg::POS_W-1:0]    cell_row,
    output logic [hpss_pkg::POS_W-1:0]    cell_col,
    output logic                          sweep_last,
    output logic                          settled,
    output logic [hpss_pkg::TEMP_W-1:0]   largest_change,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic                          cfg_index,
    input  logic [hpss_pkg::TEMP_W-1:0]   cfg_data
);
    import hpss_pkg::*;

    localparam int RW   = $clog2(ROWS);
    localparam int CW   = $clog2(COLS);
    localparam int TAPS = 2 * COLS;

    logic [RW-1:0]      in_row_reg;
    logic [CW-1:0]      in_col_reg;
    logic               flush_reg;
    temp_t              heater_reg;
    logic [LIMIT_W-1:0] limit_reg;

    temp_t              tap_q [TAPS];

    logic               adv;
    logic               in_xfer;
    logic               step;
    logic [RW-1:0]      row_e;
    logic [CW-1:0]      col_e;
    logic               has_above;
    logic               has_below;
    logic               has_left;
    logic               has_right;
    logic               has_heater;
    logic [SUM_W-1:0]   sum_next;
    logic [CNT_W-1:0]   terms_next;
    hpss_meta_t         meta_next;

    logic               v1_reg, v2_reg, v3_reg, v4_reg;
    logic [SUM_W-1:0]   sum1_reg;
    logic [CNT_W-1:0]   terms1_reg;
    temp_t              mid1_reg, mid2_reg, mid3_reg;
    hpss_meta_t         meta1_reg, meta2_reg, meta3_reg, meta4_reg;

    logic [TEMP_W-1:0]  quot;
    temp_t              new3;
    logic [TEMP_W:0]    diff_up;
    logic [TEMP_W:0]    diff_dn;
    logic [TEMP_W-1:0]  chg_next;
    temp_t              new4_reg;
    logic [TEMP_W-1:0]  chg4_reg;

    logic [TEMP_W-1:0]  max_reg;
    logic [TEMP_W-1:0]  run_max;
    logic               out_valid_reg;
    temp_t              new_temp_reg;
    hpss_meta_t         out_meta_reg;
    logic               settled_reg;
    logic [TEMP_W-1:0]  largest_reg;

    // The whole pipeline moves together; it halts only on a held result.
    assign adv      = !out_valid_reg || out_ready;
    assign in_ready = adv && !flush_reg;
    assign in_xfer  = in_valid && in_ready;
    assign step     = in_xfer || (adv && flush_reg);

    assign cfg_ready = 1'b1;

    // Tap chain: tap_q[0] holds the newest cell.
    for (genvar k = 0; k < TAPS; k++)
    begin : g_tap
        if (k == 0)
        begin : g_head
            hpss_tap u_tap (
                .clk   (clk),
                .shift (step),
                .din   (old_temp),
                .dout  (tap_q[k])
            );
        end
        else
        begin : g_body
            hpss_tap u_tap (
                .clk   (clk),
                .shift (step),
                .din   (tap_q[k-1]),
                .dout  (tap_q[k])
            );
        end
    end

    // Normal transfer at (r, c) updates (r-1, c); a flush step updates the last row.
    assign row_e      = flush_reg ? RW'(ROWS - 1) : in_row_reg - RW'(1);
    assign col_e      = in_col_reg;
    assign has_above  = (row_e != '0);
    assign has_below  = !flush_reg;
    assign has_left   = (col_e != '0);
    assign has_right  = (col_e != CW'(COLS - 1));
    assign has_heater = (row_e == RW'(1)) && (col_e == '0);

    always_comb
    begin
        sum_next = biased(tap_q[COLS-1])
                 + (has_above  ? biased(tap_q[TAPS-1]) : '0)
                 + (has_below  ? biased(old_temp)      : '0)
                 + (has_left   ? biased(tap_q[COLS])   : '0)
                 + (has_right  ? biased(tap_q[COLS-2]) : '0)
                 + (has_heater ? biased(heater_reg)    : '0);
        terms_next = CNT_W'(1) + CNT_W'(has_above) + CNT_W'(has_below)
                   + CNT_W'(has_left) + CNT_W'(has_right) + CNT_W'(has_heater);
        meta_next.row  = POS_W'(row_e);
        meta_next.col  = POS_W'(col_e);
        meta_next.last = flush_reg && (col_e == CW'(COLS - 1));
    end

    hpss_div u_div (
        .clk   (clk),
        .en    (adv),
        .num   (sum1_reg),
        .terms (terms1_reg),
        .quot  (quot)
    );

    // Remove the 2^23 bias of the quotient.
    assign new3     = {~quot[TEMP_W-1], quot[TEMP_W-2:0]};
    assign diff_up  = {new3[TEMP_W-1], new3} - {mid3_reg[TEMP_W-1], mid3_reg};
    assign diff_dn  = {mid3_reg[TEMP_W-1], mid3_reg} - {new3[TEMP_W-1], new3};
    assign chg_next = diff_up[TEMP_W] ? diff_dn[TEMP_W-1:0] : diff_up[TEMP_W-1:0];

    assign run_max = (chg4_reg > max_reg) ? chg4_reg : max_reg;

    // Position counters and flush control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_row_reg <= '0;
            in_col_reg <= '0;
            flush_reg  <= 1'b0;
        end
        else if (step)
        begin
            if (in_col_reg == CW'(COLS - 1))
            begin
                in_col_reg <= '0;
                if (flush_reg)
                begin
                    flush_reg <= 1'b0;
                end
                else if (in_row_reg == RW'(ROWS - 1))
                begin
                    in_row_reg <= '0;
                    flush_reg  <= 1'b1;
                end
                else
                begin
                    in_row_reg <= in_row_reg + RW'(1);
                end
            end
            else
            begin
                in_col_reg <= in_col_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heater_reg <= '0;
            limit_reg  <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_HEATER: heater_reg <= temp_t'(cfg_data);
                CFG_LIMIT:  limit_reg  <= cfg_data[LIMIT_W-1:0];
                default:    limit_reg  <= limit_reg;
            endcase
        end
    end

    // Pipeline valids and running maximum
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            max_reg       <= '0;
        end
        else if (adv)
        begin
            v1_reg        <= step && (flush_reg || (in_row_reg != '0));
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            v4_reg        <= v3_reg;
            out_valid_reg <= v4_reg;
            if (v4_reg)
            begin
                max_reg <= meta4_reg.last ? '0 : run_max;
            end
        end
    end

    // Pipeline payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sum1_reg     <= sum_next;
            terms1_reg   <= terms_next;
            mid1_reg     <= tap_q[COLS-1];
            meta1_reg    <= meta_next;
            mid2_reg     <= mid1_reg;
            meta2_reg    <= meta1_reg;
            mid3_reg     <= mid2_reg;
            meta3_reg    <= meta2_reg;
            new4_reg     <= new3;
            chg4_reg     <= chg_next;
            meta4_reg    <= meta3_reg;
            new_temp_reg <= new4_reg;
            out_meta_reg <= meta4_reg;
            largest_reg  <= run_max;
            settled_reg  <= meta4_reg.last && (run_max < TEMP_W'(limit_reg));
        end
    end

    assign out_valid      = out_valid_reg;
    assign new_temp       = new_temp_reg;
    assign cell_row       = out_meta_reg.row;
    assign cell_col       = out_meta_reg.col;
    assign sweep_last     = out_meta_reg.last;
    assign settled        = settled_reg;
    assign largest_change = largest_reg;

endmodule

FILE: src/hpss_tap.sv
module hpss_tap (
    input  logic            clk,
    input  logic            shift,
    input  hpss_pkg::temp_t din,
    output hpss_pkg::temp_t dout
);
    import hpss_pkg::*;

    temp_t value_reg;

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            value_reg <= din;
        end
    end

    assign dout = value_reg;

endmodule

FILE: src/hpss_div.sv
module hpss_div (
    input  logic                         clk,
    input  logic                         en,
    input  logic [hpss_pkg::SUM_W-1:0]   num,
    input  logic [hpss_pkg::CNT_W-1:0]   terms,
    output logic [hpss_pkg::TEMP_W-1:0]  quot
);
    import hpss_pkg::*;

    logic [PROD_W-1:0] prod;
    logic [TEMP_W-1:0] est_reg;
    logic [REM_W-1:0]  num_lo_reg;
    logic [CNT_W-1:0]  terms_reg;
    logic [REM_W-1:0]  rem;
    logic              bump;
    logic [TEMP_W-1:0] quot_reg;
    logic [TEMP_W-1:0] quot_next;

    assign prod = PROD_W'(num) * PROD_W'(recip(terms));

    // Estimate is exact or one low; the true remainder is below 2n, so four bits do.
    assign rem       = num_lo_reg - est_reg[REM_W-1:0] * REM_W'(terms_reg);
    assign bump      = (rem >= REM_W'(terms_reg));
    assign quot_next = est_reg + TEMP_W'(bump);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            est_reg    <= prod[RECIP_SHIFT+TEMP_W-1:RECIP_SHIFT];
            num_lo_reg <= num[REM_W-1:0];
            terms_reg  <= terms;
            quot_reg   <= quot_next;
        end
    end

    assign quot = quot_reg;

endmodule

FILE: src/hpss_check.sv
`include "assert_macros.svh"

module hpss_check #(
    parameter int ROWS = 8,
    parameter int COLS = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_ready,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  hpss_pkg::temp_t               new_temp,
    input  logic [hpss_pkg::POS_W-1:0]    cell_row,
    input  logic [hpss_pkg::POS_W-1:0]    cell_col,
    input  logic                          sweep_last,
    input  logic                          settled,
    input  logic [hpss_pkg::TEMP_W-1:0]   largest_change
);
    import hpss_pkg::*;

    logic [TEMP_W-1:0] prev_max_reg;
    logic              prev_last_reg;
    logic              out_xfer;

    assign out_xfer = out_valid && out_ready;

    // Track the previous result of the sweep.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_max_reg  <= '0;
            prev_last_reg <= 1'b1;
        end
        else if (out_xfer)
        begin
            prev_max_reg  <= largest_change;
            prev_last_reg <= sweep_last;
        end
    end

    `HPSS_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(new_temp) && $stable(cell_row) && $stable(cell_col) && $stable(largest_change))
    `HPSS_ASSERT_IMP(a_in_held, clk, rst_n, out_valid && !out_ready, !in_ready)
    `HPSS_ASSERT_IMP(a_settled_last, clk, rst_n, out_valid && settled, sweep_last)
    `HPSS_ASSERT_IMP(a_last_corner, clk, rst_n, out_valid && sweep_last, (cell_row == POS_W'(ROWS - 1)) && (cell_col == POS_W'(COLS - 1)))
    `HPSS_ASSERT_IMP(a_max_grows, clk, rst_n, out_valid && !prev_last_reg, largest_change >= prev_max_reg)

endmodule

bind heat_plate_stencil_sweep_core hpss_check #(
    .ROWS (ROWS),
    .COLS (COLS)
) u_hpss_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_ready       (in_ready),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .new_temp       (new_temp),
    .cell_row       (cell_row),
    .cell_col       (cell_col),
    .sweep_last     (sweep_last),
    .settled        (settled),
    .largest_change (largest_change)
);

FILE: tb/heat_plate_stencil_sweep_core_tb.sv
`timescale 1ns / 1ps

module heat_plate_stencil_sweep_core_tb;
    import hpss_pkg::*;

    localparam int ROWS          = 8;
    localparam int COLS          = 8;
    localparam int SETTLE_CYCLES = 2 * COLS + 8;
    localparam int STUCK_LIMIT   = 1000;
    localparam int RANDOM_SWEEPS = 1;

    localparam temp_t TEMP_MAX = temp_t'(24'h7FFFFF);
    localparam temp_t TEMP_MIN = temp_t'(24'h800000);

    typedef temp_t row_buf_t [COLS];

    typedef struct {
        temp_t              temp;
        logic [POS_W-1:0]   row;
        logic [POS_W-1:0]   col;
        logic               last;
        logic               settled;
        logic [TEMP_W-1:0]  change;
    } cell_result_t;

    logic                clk            = 1'b0;
    logic                rst_n          = 1'b0;
    logic                in_valid       = 1'b0;
    logic                in_ready;
    temp_t               old_temp       = '0;
    logic                out_valid;
    logic                out_ready      = 1'b0;
    temp_t               new_temp;
    logic [POS_W-1:0]    cell_row;
    logic [POS_W-1:0]    cell_col;
    logic                sweep_last;
    logic                settled;
    logic [TEMP_W-1:0]   largest_change;
    logic                cfg_valid      = 1'b0;
    logic                cfg_ready;
    logic                cfg_index      = CFG_HEATER;
    logic [TEMP_W-1:0]   cfg_data       = '0;

    // plate state as the block should hold it
    row_buf_t            row_up;
    row_buf_t            row_mid;
    row_buf_t            row_in;
    int                  at_row         = 0;
    int                  at_col         = 0;
    logic [TEMP_W-1:0]   peak_change    = '0;
    temp_t               heater_now     = '0;
    logic [LIMIT_W-1:0]  limit_now      = '0;

    cell_result_t        pending_cells[$];
    int                  errors         = 0;
    bit                  calm_tail      = 1'b0;
    int                  stall_left     = 0;
    int                  quiet_cycles   = 0;

    heat_plate_stencil_sweep_core #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .old_temp       (old_temp),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .new_temp       (new_temp),
        .cell_row       (cell_row),
        .cell_col       (cell_col),
        .sweep_last     (sweep_last),
        .settled        (settled),
        .largest_change (largest_change),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always #2 clk = ~clk;

    // floor of the mean over the cell, its in-plate neighbours and the heater at (1,0)
    function automatic temp_t relax_cell(input int row, input int col,
                                         input row_buf_t up, input row_buf_t mid,
                                         input row_buf_t dn);
        longint total;
        longint terms;
        longint quot;
        total = mid[col];
        terms = 1;
        if (row > 0) begin
            total += up[col];
            terms++;
        end
        if (row < ROWS - 1) begin
            total += dn[col];
            terms++;
        end
        if (col > 0) begin
            total += mid[col - 1];
            terms++;
        end
        if (col < COLS - 1) begin
            total += mid[col + 1];
            terms++;
        end
        if (row == 1 && col == 0) begin
            total += heater_now;
            terms++;
        end
        quot = total / terms;
        if (quot * terms != total && total < 0)
            quot--;
        return temp_t'(quot);
    endfunction

    function automatic void queue_cell(input int row, input int col,
                                       input row_buf_t up, input row_buf_t mid,
                                       input row_buf_t dn);
        cell_result_t r;
        longint delta;
        logic [TEMP_W-1:0] mag;
        r.temp = relax_cell(row, col, up, mid, dn);
        delta = longint'(r.temp) - longint'(mid[col]);
        if (delta < 0)
            delta = -delta;
        mag = delta[TEMP_W-1:0];
        if (mag > peak_change)
            peak_change = mag;
        r.row = row[POS_W-1:0];
        r.col = col[POS_W-1:0];
        r.last = (row == ROWS - 1) && (col == COLS - 1);
        r.settled = r.last && (peak_change < {1'b0, limit_now});
        r.change = peak_change;
        pending_cells.push_back(r);
    endfunction

    // advance the plate by one accepted cell; output trails input by one row
    function automatic void take_cell(input temp_t v);
        int r;
        int c;
        r = at_row;
        c = at_col;
        row_in[c] = v;
        if (r >= 1)
            queue_cell(r - 1, c, row_up, row_mid, row_in);
        if (c == COLS - 1) begin
            if (r == ROWS - 1) begin
                for (int j = 0; j < COLS; j++)
                    queue_cell(r, j, row_mid, row_in, row_in);
                at_row = 0;
                at_col = 0;
                peak_change = '0;
            end
            else begin
                row_up = row_mid;
                row_mid = row_in;
                at_row = r + 1;
                at_col = 0;
            end
        end
        else begin
            at_col = c + 1;
        end
    endfunction

    function automatic temp_t pick_extreme();
        case ($urandom_range(0, 3))
            0:       return TEMP_MAX;
            1:       return TEMP_MIN;
            2:       return '0;
            default: return '1;
        endcase
    endfunction

    function automatic void check_field(input string what, input longint want,
                                        input longint got, input int row, input int col);
        if (want != got) begin
            errors++;
            $display("%0t: cell (%0d,%0d) %s expected %0d, got %0d",
                     $time, row, col, what, want, got);
        end
    endfunction

    task automatic send_cell(input temp_t v);
        if (!calm_tail && $urandom_range(0, 5) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        in_valid <= 1'b1;
        old_temp <= v;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        take_cell(v);
    endtask

    // heater first, then limit; valid stays up across both transfers
    task automatic write_regs(input logic [TEMP_W-1:0] heater_data,
                              input logic [TEMP_W-1:0] limit_data);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_HEATER;
        cfg_data <= heater_data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        heater_now = temp_t'(heater_data);
        cfg_index <= CFG_LIMIT;
        cfg_data <= limit_data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        limit_now = limit_data[LIMIT_W-1:0];
        cfg_valid <= 1'b0;
    endtask

    // hold input until every expected result is out, then let the pipeline empty
    task automatic drain();
        in_valid <= 1'b0;
        while (pending_cells.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // reset-time registers, plate of full-scale extremes and one row of 0 and -1
    task automatic test_extreme_plate();
        temp_t v;
        for (int r = 0; r < ROWS; r++) begin
            for (int c = 0; c < COLS; c++) begin
                case (r)
                    0, 1:    v = ((r + c) % 2 != 0) ? TEMP_MIN : TEMP_MAX;
                    2, 3:    v = TEMP_MAX;
                    4, 5:    v = TEMP_MIN;
                    6:       v = (c % 2 != 0) ? temp_t'('1) : temp_t'('0);
                    default: v = (c % 2 != 0) ? TEMP_MAX : TEMP_MIN;
                endcase
                send_cell(v);
            end
        end
        drain();
    endtask

    // registers rewritten after the first row; limit has bit 23 set in the write data
    task automatic test_config_mid_sweep();
        write_regs(TEMP_MIN, 24'h7FFFFF);
        for (int c = 0; c < COLS; c++)
            send_cell(TEMP_MAX);
        drain();
        write_regs(TEMP_MAX, 24'h800001);
        for (int r = 1; r < ROWS; r++)
            for (int c = 0; c < COLS; c++)
                send_cell(TEMP_MAX);
        drain();
    endtask

    // cold plate, heater lifts (1,0) by exactly the limit: not settled
    task automatic test_limit_equal();
        write_regs(24'd15, 24'd3);
        for (int r = 0; r < ROWS; r++)
            for (int c = 0; c < COLS; c++)
                send_cell('0);
        drain();
    endtask

    task automatic test_random_sweeps();
        temp_t base;
        bit smooth;
        logic [TEMP_W-1:0] heater_data;
        logic [TEMP_W-1:0] limit_data;
        temp_t v;
        for (int s = 0; s < RANDOM_SWEEPS; s++) begin
            calm_tail = (s == RANDOM_SWEEPS - 1);
            smooth = 1'($urandom_range(0, 1));
            base = temp_t'(int'($urandom_range(0, 16775168)) - 8387584);
            case ($urandom_range(0, 3))
                0:       heater_data = pick_extreme();
                1:       heater_data = temp_t'(int'(base) + int'($urandom_range(0, 2000)) - 1000);
                default: heater_data = TEMP_W'($urandom());
            endcase
            case ($urandom_range(0, 3))
                0:       limit_data[LIMIT_W-1:0] = '0;
                1:       limit_data[LIMIT_W-1:0] = '1;
                2:       limit_data[LIMIT_W-1:0] = LIMIT_W'($urandom_range(0, 600));
                default: limit_data[LIMIT_W-1:0] = LIMIT_W'($urandom());
            endcase
            limit_data[TEMP_W-1] = 1'($urandom_range(0, 1));
            write_regs(heater_data, limit_data);
            for (int r = 0; r < ROWS; r++) begin
                for (int c = 0; c < COLS; c++) begin
                    if (smooth)
                        v = temp_t'(int'(base) + int'($urandom_range(0, 510)) - 255);
                    else if ($urandom_range(0, 9) == 0)
                        v = pick_extreme();
                    else
                        v = temp_t'($urandom());
                    send_cell(v);
                end
            end
            drain();
        end
    endtask

    always @(posedge clk) begin : result_check
        cell_result_t want;
        if (rst_n && out_valid && out_ready) begin
            if (pending_cells.size() == 0) begin
                errors++;
                $display("%0t: result with none expected: cell (%0d,%0d) new_temp %0d",
                         $time, cell_row, cell_col, new_temp);
            end
            else begin
                want = pending_cells.pop_front();
                check_field("new_temp", want.temp, new_temp, want.row, want.col);
                check_field("cell_row", want.row, cell_row, want.row, want.col);
                check_field("cell_col", want.col, cell_col, want.row, want.col);
                check_field("sweep_last", want.last, sweep_last, want.row, want.col);
                check_field("settled", want.settled, settled, want.row, want.col);
                check_field("largest_change", want.change, largest_change,
                            want.row, want.col);
            end
        end
        if (stall_left > 0) begin
            stall_left--;
            out_ready <= 1'b0;
        end
        else if (!calm_tail && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 14);
            out_ready <= 1'b0;
        end
        else begin
            out_ready <= 1'b1;
        end
    end

    // drop the run if no transfer happens for too long
    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STUCK_LIMIT) begin
                $display("heat_plate_stencil_sweep_core_tb: errors");
                $finish;
            end
        end
    end

    initial begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_extreme_plate();
        test_config_mid_sweep();
        test_limit_equal();
        test_random_sweeps();
        drain();
        if (errors == 0 && pending_cells.size() == 0)
            $display("heat_plate_stencil_sweep_core_tb: clean");
        else
            $display("heat_plate_stencil_sweep_core_tb: errors");
        $finish;
    end

endmodule
